// ===== src/rfs_pkg.sv =====
// Package: shared types and constants for the robust feature scaler.
`timescale 1ns / 1ps
package rfs_pkg;
    localparam int DATA_W = 32;
    localparam int IQR_W = 31;
    localparam int IDX_W = 6;
    localparam int STAT_W = 2;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_XFORM = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK = 2'd0,
        ST_NOT_LOADED = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;
endpackage

// ===== src/rfs_req_if.sv =====
// Interface: input request channel of the robust feature scaler.
`timescale 1ns / 1ps
interface rfs_req_if;
    logic valid;
    logic ready;
    logic opcode;
    logic [5:0] feature_index;
    logic signed [31:0] sample_value;
    logic signed [31:0] median_value;
    logic [30:0] iqr_value;
    logic signed [31:0] clip_low_value;
    logic signed [31:0] clip_high_value;
    modport source (output valid, opcode, feature_index, sample_value, median_value,
                    iqr_value, clip_low_value, clip_high_value, input ready);
    modport sink (input valid, opcode, feature_index, sample_value, median_value,
                  iqr_value, clip_low_value, clip_high_value, output ready);
endinterface

// ===== src/rfs_res_if.sv =====
// Interface: result channel of the robust feature scaler.
`timescale 1ns / 1ps
interface rfs_res_if;
    logic valid;
    logic ready;
    logic signed [31:0] scaled_value;
    logic [5:0] result_index;
    logic [1:0] status;
    modport source (output valid, scaled_value, result_index, status, input ready);
    modport sink (input valid, scaled_value, result_index, status, output ready);
endinterface

// ===== src/rfs_div.sv =====
// Pipelined signed divider: one quotient bit per stage, one request per cycle while en is high.
`timescale 1ns / 1ps
module rfs_div
    import rfs_pkg::*;
#(
    parameter int TAG_W = 8
)(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [DATA_W:0] dividend,
    input  logic [IQR_W-1:0] divisor,
    input  logic [TAG_W-1:0] in_tag,
    output logic out_valid,
    output logic signed [DATA_W-1:0] quotient,
    output logic saturated,
    output logic [TAG_W-1:0] out_tag
);
    // magnitude of d*65536 is below 2^49
    localparam int NW = 49;
    localparam int ST = NW;

    logic [ST:0] v_reg;
    logic [NW-1:0] rem_reg [ST+1];
    logic [NW-1:0] num_reg [ST+1];
    logic [IQR_W-1:0] den_reg [ST+1];
    logic neg_reg [ST+1];
    logic [TAG_W-1:0] tag_reg [ST+1];

    logic [DATA_W:0] mag;
    assign mag = dividend[DATA_W] ? (DATA_W+1)'(0) - dividend : dividend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[ST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            num_reg[0] <= {mag[NW-17:0], 16'd0};
            den_reg[0] <= divisor;
            neg_reg[0] <= dividend[DATA_W];
            tag_reg[0] <= in_tag;
            for (int s = 0; s < ST; s++)
            begin
                logic [NW:0] trial;
                trial = {rem_reg[s], num_reg[s][NW-1]} - {{(NW-IQR_W+1){1'b0}}, den_reg[s]};
                if (!trial[NW])
                begin
                    rem_reg[s+1] <= trial[NW-1:0];
                    num_reg[s+1] <= {num_reg[s][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= {rem_reg[s][NW-2:0], num_reg[s][NW-1]};
                    num_reg[s+1] <= {num_reg[s][NW-2:0], 1'b0};
                end
                den_reg[s+1] <= den_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    logic [NW-1:0] q;
    assign q = num_reg[ST];
    always_comb
    begin
        quotient = '0;
        saturated = 1'b0;
        if (neg_reg[ST])
        begin
            if (q > NW'(64'h80000000))
            begin
                quotient = 32'sh80000000;
                saturated = 1'b1;
            end
            else
            begin
                quotient = DATA_W'(NW'(0) - q);
            end
        end
        else if (q > NW'(64'h7fffffff))
        begin
            quotient = 32'sh7fffffff;
            saturated = 1'b1;
        end
        else
        begin
            quotient = q[DATA_W-1:0];
        end
    end
    assign out_valid = v_reg[ST];
    assign out_tag = tag_reg[ST];
endmodule

// ===== src/robust_feature_scaler.sv =====
// Top level: robust feature scaler with per-feature table and pipelined divider.
`timescale 1ns / 1ps
// Usage:
//   req channel carries load and transform requests; res channel returns one
//   result per transform request and none per load.
//   A load writes median, IQR and clip bounds of one feature into the table
//   memory and marks the entry loaded.
//   A transform reads the entry (registered memory read), clamps, subtracts the
//   median, then runs a 49-stage restoring divider, one quotient bit a stage.
//   Throughput is one request per cycle while the receiver does not stall,
//   set by the fully pipelined divider.
//   A transform right after a load of the same feature sees the new entry:
//   the write lands at the edge before the read.
//   Reset clears all loaded flags at once; table contents need no clearing.
//   When the receiver stalls, the whole pipeline holds, and ready drops
//   until the output register is taken; requests are never lost.
module robust_feature_scaler
    import rfs_pkg::*;
#(
    parameter int NUM_FEATURES = 64
)(
    input  logic clk,
    input  logic rst_n,
    rfs_req_if.sink req,
    rfs_res_if.source res
);
    localparam int TAG_W = IDX_W + 2;

    // how the result of a transform is formed
    localparam logic [1:0] KIND_CALC = 2'd0;
    localparam logic [1:0] KIND_NOT_LOADED = 2'd1;
    localparam logic [1:0] KIND_ZERO = 2'd2;

    logic en;
    logic out_v;
    assign en = !out_v || res.ready;
    assign req.ready = en;

    logic acc;
    assign acc = req.valid && en;
    logic in_range;
    assign in_range = 32'(req.feature_index) < NUM_FEATURES;

    logic [DATA_W-1:0] med_mem [64];
    logic [IQR_W-1:0] iqr_mem [64];
    logic [DATA_W-1:0] lo_mem [64];
    logic [DATA_W-1:0] hi_mem [64];
    logic [63:0] loaded_reg;

    logic we;
    assign we = acc && req.opcode == OP_LOAD && in_range;

    // stage 1: memory read
    logic s1_v_reg, s1_ld_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic signed [DATA_W-1:0] s1_x_reg, med_rd, lo_rd, hi_rd;
    logic [IQR_W-1:0] iqr_rd;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            med_mem[req.feature_index] <= req.median_value;
            iqr_mem[req.feature_index] <= req.iqr_value;
            lo_mem[req.feature_index] <= req.clip_low_value;
            hi_mem[req.feature_index] <= req.clip_high_value;
        end
        if (en)
        begin
            med_rd <= med_mem[req.feature_index];
            iqr_rd <= iqr_mem[req.feature_index];
            lo_rd <= lo_mem[req.feature_index];
            hi_rd <= hi_mem[req.feature_index];
            s1_idx_reg <= req.feature_index;
            s1_x_reg <= req.sample_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
            s1_v_reg <= 1'b0;
            s1_ld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                loaded_reg[req.feature_index] <= 1'b1;
            end
            if (en)
            begin
                s1_v_reg <= acc && req.opcode == OP_XFORM;
                s1_ld_reg <= in_range && loaded_reg[req.feature_index];
            end
        end
    end

    logic signed [DATA_W-1:0] med, lo, hi, xc;
    logic [IQR_W-1:0] iqr;
    always_comb
    begin
        med = med_rd;
        iqr = iqr_rd;
        lo = lo_rd;
        hi = hi_rd;
        if (s1_x_reg < lo)
        begin
            xc = lo;
        end
        else if (s1_x_reg > hi)
        begin
            xc = hi;
        end
        else
        begin
            xc = s1_x_reg;
        end
    end

    // stage 2: difference, zero and not-loaded handling
    logic s2_v_reg;
    logic [1:0] s2_kind_reg;
    logic signed [DATA_W:0] s2_d_reg;
    logic [IQR_W-1:0] s2_iqr_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_d_reg <= (DATA_W+1)'(xc) - (DATA_W+1)'(med);
            s2_iqr_reg <= (iqr == '0) ? IQR_W'(1) : iqr;
            s2_idx_reg <= s1_idx_reg;
            s2_kind_reg <= !s1_ld_reg ? KIND_NOT_LOADED :
                           (iqr == '0 ? KIND_ZERO : KIND_CALC);
        end
    end

    logic dv;
    logic signed [DATA_W-1:0] dq;
    logic dsat;
    logic [TAG_W-1:0] dtag;
    rfs_div #(.TAG_W(TAG_W)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_v_reg),
        .dividend(s2_d_reg), .divisor(s2_iqr_reg),
        .in_tag({s2_kind_reg, s2_idx_reg}),
        .out_valid(dv), .quotient(dq), .saturated(dsat), .out_tag(dtag)
    );

    logic signed [DATA_W-1:0] o_val_reg;
    logic [IDX_W-1:0] o_idx_reg;
    logic [STAT_W-1:0] o_st_reg;
    logic out_v_reg;
    assign out_v = out_v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dv;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_idx_reg <= dtag[IDX_W-1:0];
            if (dtag[TAG_W-1 -: 2] == KIND_NOT_LOADED)
            begin
                o_val_reg <= '0;
                o_st_reg <= ST_NOT_LOADED;
            end
            else if (dtag[TAG_W-1 -: 2] == KIND_ZERO)
            begin
                o_val_reg <= '0;
                o_st_reg <= ST_OK;
            end
            else
            begin
                o_val_reg <= dq;
                o_st_reg <= dsat ? ST_SATURATED : ST_OK;
            end
        end
    end
    assign res.valid = out_v_reg;
    assign res.scaled_value = o_val_reg;
    assign res.result_index = o_idx_reg;
    assign res.status = o_st_reg;
endmodule
